@@ src/usb_transfer_packetizer_macros.svh @@
// assertion macros used by the usb transfer packetizer datapath
// expects signals named clock and reset in the scope of each use
`ifndef USB_TRANSFER_PACKETIZER_MACROS_SVH
`define USB_TRANSFER_PACKETIZER_MACROS_SVH

// same-cycle implication
`define UTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/utp_pkg.sv @@
// shared types, codes and helpers for the usb transfer packetizer
// no dependencies
`timescale 1ns / 1ps

package utp_pkg;

   localparam int unsigned MaxTransfer = 504;
   localparam int unsigned MinChunk    = 8;
   localparam int unsigned SetupBytes  = 8;

   localparam int unsigned RegW  = 11;
   localparam int unsigned LenW  = 9;
   localparam int unsigned AddrW = 5;
   localparam int unsigned DataW = 32;

   // request and packet kinds
   localparam logic [1:0] CMD_SETUP = 2'd0;
   localparam logic [1:0] CMD_IN    = 2'd1;
   localparam logic [1:0] CMD_OUT   = 2'd2;

   // transfer types
   localparam logic [1:0] TT_CONTROL   = 2'd0;
   localparam logic [1:0] TT_BULK      = 2'd1;
   localparam logic [1:0] TT_INTERRUPT = 2'd2;
   localparam logic [1:0] TT_ISOC      = 2'd3;

   // register indexes (byte address is 4 times the index)
   localparam logic [2:0] REG_MAX_PACKET      = 3'd0;
   localparam logic [2:0] REG_CONTROL_SPLIT   = 3'd1;
   localparam logic [2:0] REG_BULK_SPLIT      = 3'd2;
   localparam logic [2:0] REG_INTERRUPT_SPLIT = 3'd3;
   localparam logic [2:0] REG_ISOC_SPLIT      = 3'd4;

   localparam logic [RegW-1:0] MAX_PACKET_RESET = 11'd64;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [1:0]      transfer_type;
      logic            force_data1;
      logic [LenW-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]      packet_kind;
      logic [RegW-1:0] packet_bytes;
      logic [LenW-1:0] byte_offset;
      logic            data_toggle;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [RegW-1:0] max_packet;
      logic [RegW-1:0] control_split;
      logic [RegW-1:0] bulk_split;
      logic [RegW-1:0] interrupt_split;
      logic [RegW-1:0] isoc_split;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic mod_step;
      logic emit_data;
      logic emit_zlp;
      logic emit_setup;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic can_load;
      logic mod_busy;
      logic final_data;
      logic zlp;
   } dp_status_type;

   function automatic logic [RegW-1:0] at_least_min(input logic [RegW-1:0] v);
      logic [RegW-1:0] r;
      r = (v < RegW'(MinChunk)) ? RegW'(MinChunk) : v;
      return r;
   endfunction

endpackage

@@ src/utp_csr.sv @@
// configuration registers behind an apb-style port
// depends on utp_pkg
`timescale 1ns / 1ps

module utp_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [utp_pkg::AddrW-1:0] paddr,
   input  logic [utp_pkg::DataW-1:0] pwdata,
   output logic [utp_pkg::DataW-1:0] prdata,
   output logic                      pready,
   output utp_pkg::cfg_type          cfg
);

   utp_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;
   logic [utp_pkg::RegW-1:0] wval;
   logic [utp_pkg::RegW-1:0] rval;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign wval    = pwdata[utp_pkg::RegW-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            utp_pkg::REG_MAX_PACKET:      cfg_in.max_packet      = wval;
            utp_pkg::REG_CONTROL_SPLIT:   cfg_in.control_split   = wval;
            utp_pkg::REG_BULK_SPLIT:      cfg_in.bulk_split      = wval;
            utp_pkg::REG_INTERRUPT_SPLIT: cfg_in.interrupt_split = wval;
            utp_pkg::REG_ISOC_SPLIT:      cfg_in.isoc_split      = wval;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         utp_pkg::REG_MAX_PACKET:      rval = cfg_ff.max_packet;
         utp_pkg::REG_CONTROL_SPLIT:   rval = cfg_ff.control_split;
         utp_pkg::REG_BULK_SPLIT:      rval = cfg_ff.bulk_split;
         utp_pkg::REG_INTERRUPT_SPLIT: rval = cfg_ff.interrupt_split;
         utp_pkg::REG_ISOC_SPLIT:      rval = cfg_ff.isoc_split;
         default:                      rval = '0;
      endcase
   end

   assign prdata = {{(utp_pkg::DataW - utp_pkg::RegW){1'b0}}, rval};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_packet      <= utp_pkg::MAX_PACKET_RESET;
         cfg_ff.control_split   <= '0;
         cfg_ff.bulk_split      <= '0;
         cfg_ff.interrupt_split <= '0;
         cfg_ff.isoc_split      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/utp_ctrl.sv @@
// sequencing state machine: accept, remainder check, packet emission
// depends on utp_pkg
`timescale 1ns / 1ps

module utp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_stall,
   input  utp_pkg::dp_status_type status,
   output utp_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_DATA,
      ST_ZLP,
      ST_SETUP
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  utp_pkg::CMD_SETUP: state_in = ST_SETUP;
                  utp_pkg::CMD_IN,
                  utp_pkg::CMD_OUT: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_MOD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOD: begin
            if (status.mod_busy) begin
               cmd.mod_step = 1'b1;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (status.can_load) begin
               cmd.emit_data = 1'b1;
               if (status.final_data) begin
                  state_in = status.zlp ? ST_ZLP : ST_IDLE;
               end
            end
         end
         ST_ZLP: begin
            if (status.can_load) begin
               cmd.emit_zlp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SETUP: begin
            if (status.can_load) begin
               cmd.emit_setup = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   assign req_stall = stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule

@@ src/utp_datapath.sv @@
// request registers, remainder unit, packet sizing, toggle and output register
// depends on utp_pkg and usb_transfer_packetizer_macros.svh
`timescale 1ns / 1ps
`include "usb_transfer_packetizer_macros.svh"

module utp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  utp_pkg::req_type      req_data,
   input  utp_pkg::cfg_type      cfg,
   input  utp_pkg::dp_cmd_type   cmd,
   output utp_pkg::dp_status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output utp_pkg::rsp_type      rsp_data
);

   localparam int unsigned LenW = utp_pkg::LenW;
   localparam int unsigned RegW = utp_pkg::RegW;

   logic [1:0]      kind_ff;
   logic [LenW-1:0] len_ff, rem_ff, offset_ff;
   logic [RegW-1:0] chunk_ff, mps_ff;
   logic            bulk_out_ff;
   logic            toggle_ff, toggle_in;
   logic            rsp_valid_ff, rsp_valid_in;
   utp_pkg::rsp_type rsp_ff, rsp_in;

   logic [LenW-1:0] len_sat;
   logic [RegW-1:0] ovr;
   logic [LenW-1:0] rest, n;
   logic [LenW:0]   next_off;
   logic            emit_any;
   logic            emit_flip;

   // request capture values
   always_comb begin
      len_sat = (req_data.byte_count > LenW'(utp_pkg::MaxTransfer))
                ? LenW'(utp_pkg::MaxTransfer) : req_data.byte_count;
      case (req_data.transfer_type)
         utp_pkg::TT_CONTROL:   ovr = cfg.control_split;
         utp_pkg::TT_BULK:      ovr = cfg.bulk_split;
         utp_pkg::TT_INTERRUPT: ovr = cfg.interrupt_split;
         default:               ovr = cfg.isoc_split;
      endcase
   end

   // chunk sizing for the next data packet
   assign rest     = len_ff - offset_ff;
   assign n        = ({{(RegW-LenW){1'b0}}, rest} < chunk_ff) ? rest : chunk_ff[LenW-1:0];
   assign next_off = {1'b0, offset_ff} + {1'b0, n};

   assign status.can_load   = ~rsp_valid_ff | ~rsp_stall;
   assign status.mod_busy   = bulk_out_ff & ({{(RegW-LenW){1'b0}}, rem_ff} >= mps_ff);
   assign status.final_data = (n == rest);
   assign status.zlp        = bulk_out_ff & (len_ff != '0) & (rem_ff == '0);

   assign emit_any  = cmd.emit_data | cmd.emit_zlp | cmd.emit_setup;
   assign emit_flip = cmd.emit_data | cmd.emit_zlp;

   always_comb begin
      rsp_in    = rsp_ff;
      toggle_in = toggle_ff;
      if (cmd.capture && req_data.force_data1) begin
         toggle_in = 1'b1;
      end
      if (cmd.emit_data) begin
         rsp_in.packet_kind  = kind_ff;
         rsp_in.packet_bytes = {{(RegW-LenW){1'b0}}, n};
         rsp_in.byte_offset  = offset_ff;
         rsp_in.data_toggle  = toggle_ff;
         rsp_in.last         = status.final_data & ~status.zlp;
         toggle_in           = ~toggle_ff;
      end else if (cmd.emit_zlp) begin
         rsp_in.packet_kind  = kind_ff;
         rsp_in.packet_bytes = '0;
         rsp_in.byte_offset  = len_ff;
         rsp_in.data_toggle  = toggle_ff;
         rsp_in.last         = 1'b1;
         toggle_in           = ~toggle_ff;
      end else if (cmd.emit_setup) begin
         rsp_in.packet_kind  = utp_pkg::CMD_SETUP;
         rsp_in.packet_bytes = RegW'(utp_pkg::SetupBytes);
         rsp_in.byte_offset  = '0;
         rsp_in.data_toggle  = 1'b0;
         rsp_in.last         = 1'b1;
         toggle_in           = 1'b1;
      end
      if (emit_any) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // request and payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_data.cmd;
         len_ff      <= len_sat;
         rem_ff      <= len_sat;
         offset_ff   <= '0;
         chunk_ff    <= utp_pkg::at_least_min((ovr != '0) ? ovr : cfg.max_packet);
         mps_ff      <= utp_pkg::at_least_min(cfg.max_packet);
      end else begin
         if (cmd.mod_step) begin
            rem_ff <= rem_ff - mps_ff[LenW-1:0];
         end
         if (cmd.emit_data) begin
            offset_ff <= next_off[LenW-1:0];
         end
      end
      rsp_ff <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bulk_out_ff  <= 1'b0;
         toggle_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            bulk_out_ff <= (req_data.cmd == utp_pkg::CMD_OUT) &&
                           (req_data.transfer_type == utp_pkg::TT_BULK);
         end
         toggle_ff    <= toggle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `UTP_ASSERT_NOW(a_load_when_free, emit_any, status.can_load, "packet over a pending one")
   `UTP_ASSERT_NEXT(a_toggle_flips, emit_flip, toggle_ff != $past(toggle_ff), "toggle stuck")
   `UTP_ASSERT_NEXT(a_offset_in_range, cmd.emit_data, offset_ff <= len_ff, "offset past length")
   `UTP_ASSERT_NOW(a_one_emit, 1'b1, $onehot0(cmd), "conflicting datapath commands")

endmodule

@@ src/usb_transfer_packetizer.sv @@
// usb transfer packetizer: splits one endpoint transfer request into bus packets
// sequence: a setup request goes from idle to the setup state, then into the output register;
// in/out requests pass the remainder check state (repeated for bulk out) before the data state
// throughput: one packet per cycle while rsp is not stalled, up to 64 per request;
// the next request is taken the cycle after the last packet enters the output register
// reset: synchronous active high, toggle to data0, max_packet to 64, splits to 0
`timescale 1ns / 1ps

module usb_transfer_packetizer (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  utp_pkg::req_type          req_data,
   // packet channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output utp_pkg::rsp_type          rsp_data,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [utp_pkg::AddrW-1:0] paddr,
   input  logic [utp_pkg::DataW-1:0] pwdata,
   output logic [utp_pkg::DataW-1:0] prdata,
   output logic                      pready
);

   utp_pkg::cfg_type      cfg;
   utp_pkg::dp_cmd_type   dp_cmd;
   utp_pkg::dp_status_type dp_status;

   // register file: endpoint max packet size and per-type chunk overrides
   utp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: one request at a time, stalls the request side while busy
   utp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // datapath: remainder by repeated subtraction for the zero-length packet test,
   // chunk sizing, data toggle and the single-entry output register
   utp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
